/* hdl/pcxrle_pkg.sv */
// pcxrle_pkg: shared types, operation codes and colour packing for the pcx rle decoder
// no dependencies; imported by pcxrle_palette, pcx_rle_palette_decoder_core and tb
package pcxrle_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

    // operation codes
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int unsigned CFG_DATA_W       = 13;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    // top two bits of a run marker byte
    localparam logic [1:0] RUN_MARK = 2'b11;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_of_run;
        logic        end_of_image;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [PAL_AW-1:0] wr_addr;
        logic [15:0]       wr_data;
        logic              rd_en;
        logic [PAL_AW-1:0] rd_addr;
    } pal_req_t;

    function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        rgb565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

/* hdl/pcx_rle_palette_decoder_core.sv */
// pcx_rle_palette_decoder_core: top level of the pcx 8-bit rle decoder with rgb565 palette
// depends on pcxrle_pkg and pcxrle_palette
//
// Decodes the 8-bit run-length stream of a pcx picture into rgb565 pixels in raster
// order. Load the palette first (operation 0): each colour is cut to 5-6-5 bits as it
// is stored; reading a palette entry that was never written gives an undefined colour.
// A data byte (operation 1) with both top bits set is a run marker carrying a count in
// its low six bits (0xc0 is a run of zero); the next data byte is the palette index
// repeated that many times. Any other data byte is one pixel. Runs wrap across rows;
// the pixel at the last column of the last row carries end_of_image, the position then
// returns to the origin and the rest of that run is dropped. Operation 2 restarts the
// image (palette kept), operation 3 is ignored. image_width and image_height take 0 as
// 1 and anything above MAX_DIM as MAX_DIM; write them only while the block is idle.
// Palette writes, restarts, markers and empty runs produce no pixel and leave the block idle; an
// input that yields pixels is first read from the palette (a registered read), then goes one
// pixel a cycle into the single output register while m_ready does not hold it off, and no
// new input is taken until its last pixel is loaded. No clearing pass after reset.
module pcx_rle_palette_decoder_core import pcxrle_pkg::*; #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // encoded input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // pixel output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [31:0] MAX_DIM_L = 32'(MAX_DIM);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  armed_reg, armed_next;
    logic [5:0]            run_len_reg, run_len_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [11:0]           col_reg, col_next;
    logic [11:0]           row_reg, row_next;
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    pal_req_t              pal_req;
    logic [15:0]           pal_rd_data;

    logic                  s_xfer;
    logic                  cfg_xfer;
    logic                  load;
    logic [CFG_DATA_W-1:0] w_eff;
    logic [CFG_DATA_W-1:0] h_eff;
    logic                  row_end;
    logic                  img_end;
    logic                  is_marker;

    // out-of-range dimensions are pulled into 1..MAX_DIM
    function automatic logic [CFG_DATA_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            clamp_dim = CFG_DATA_W'(1);
        end else if (32'(v) > MAX_DIM_L) begin
            clamp_dim = MAX_DIM_L[CFG_DATA_W-1:0];
        end else begin
            clamp_dim = v;
        end
    endfunction

    pcxrle_palette u_palette (
        .aclk    (aclk),
        .req     (pal_req),
        .rd_data (pal_rd_data)
    );

    // input is taken only between items; the output register may still hold a pixel
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a new pixel goes into the output register when it is empty or being drained
    assign load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign w_eff     = clamp_dim(width_reg);
    assign h_eff     = clamp_dim(height_reg);
    // "at or beyond" tests so a shrunken image wraps at the next pixel
    assign row_end   = ({1'b0, col_reg} + 13'd1) >= w_eff;
    assign img_end   = row_end && (({1'b0, row_reg} + 13'd1) >= h_eff);
    assign is_marker = (s_item.data_byte[7:6] == RUN_MARK);

    // palette port: writes and the colour read both happen at the input transfer
    always_comb begin
        pal_req.wr_en   = s_xfer && (s_item.operation == OP_PALETTE);
        pal_req.wr_addr = s_item.entry_index;
        pal_req.wr_data = rgb565(s_item.red, s_item.green, s_item.blue);
        pal_req.rd_en   = s_xfer && (s_item.operation == OP_DATA);
        pal_req.rd_addr = s_item.data_byte;
    end

    always_comb begin
        state_next   = state_reg;
        armed_next   = armed_reg;
        run_len_next = run_len_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (cfg_xfer) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        // output register drains on a transfer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    unique case (s_item.operation)
                        OP_RESTART: begin
                            armed_next   = 1'b0;
                            run_len_next = '0;
                            col_next     = '0;
                            row_next     = '0;
                        end
                        OP_DATA: begin
                            if (armed_reg) begin
                                // this byte is the run index; an empty run yields nothing
                                armed_next   = 1'b0;
                                run_len_next = '0;
                                cnt_next     = run_len_reg;
                                if (run_len_reg != '0) begin
                                    state_next = ST_EMIT;
                                end
                            end else if (is_marker) begin
                                armed_next   = 1'b1;
                                run_len_next = s_item.data_byte[5:0];
                            end else begin
                                cnt_next   = 6'd1;
                                state_next = ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next             = 1'b1;
                    m_item_next.pixel        = pal_rd_data;
                    m_item_next.column       = col_reg;
                    m_item_next.row          = row_reg;
                    m_item_next.end_of_image = img_end;
                    m_item_next.last_of_run  = img_end || (cnt_reg == 6'd1);
                    cnt_next                 = cnt_reg - 6'd1;
                    if (img_end) begin
                        // back to the origin, rest of the run dropped
                        col_next   = '0;
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        if (row_end) begin
                            col_next = '0;
                            row_next = row_reg + 12'd1;
                        end else begin
                            col_next = col_reg + 12'd1;
                        end
                        if (cnt_reg == 6'd1) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            armed_reg   <= 1'b0;
            run_len_reg <= '0;
            cnt_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            width_reg   <= IMAGE_WIDTH_RST;
            height_reg  <= IMAGE_HEIGHT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            armed_reg   <= armed_next;
            run_len_reg <= run_len_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // pixel payload needs no reset
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

endmodule

/* hdl/pcxrle_palette.sv */
// pcxrle_palette: 256 x 16 palette memory, one write and one registered read per cycle
// depends on pcxrle_pkg for the request struct
module pcxrle_palette import pcxrle_pkg::*; (
    input  logic        aclk,
    input  pal_req_t    req,
    output logic [15:0] rd_data
);

    logic [15:0] mem [PALETTE_ENTRIES];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* dv/tb.sv */
// tb: self-checking regression for pcx_rle_palette_decoder_core (pcx 8-bit rle to rgb565)
// depends on pcxrle_pkg and the core; a scoreboard class predicts every pixel transfer
// from the accepted input transfers and the image size registers
`timescale 1ns / 100ps

module tb import pcxrle_pkg::*;;

    localparam int unsigned MAX_DIM         = 4096;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned ITEMS_PER_SHAPE = 42;
    localparam int unsigned SHAPES          = 9;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the decoder state, expected pixels in order
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        logic [15:0] palette [PALETTE_ENTRIES];
        bit          armed;
        logic [5:0]  run_count;
        logic [11:0] col;
        logic [11:0] row;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        out_item_t   expected_pixels[$];
        int unsigned dim_limit;
        int unsigned errors;
        int unsigned shown;
        int unsigned pixels_checked;
        int unsigned images_done;

        function new(int unsigned max_dim);
            dim_limit      = max_dim;
            armed          = 1'b0;
            run_count      = '0;
            col            = '0;
            row            = '0;
            width_reg      = IMAGE_WIDTH_RST;
            height_reg     = IMAGE_HEIGHT_RST;
            errors         = 0;
            shown          = 0;
            pixels_checked = 0;
            images_done    = 0;
            foreach (palette[i]) palette[i] = '0;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // append one expected pixel at the tail
        function void queue_pixel(out_item_t p);
            expected_pixels = {expected_pixels, p};
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH) width_reg = value;
            else if (idx == REG_IMAGE_HEIGHT) height_reg = value;
        endfunction

        // zero acts as one, anything above the limit as the limit
        function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
            if (v == '0) return 1;
            if (int'(v) > dim_limit) return dim_limit;
            return v;
        endfunction

        // raster placement of count copies of one colour
        function void paint_run(logic [7:0] idx, int unsigned count);
            int unsigned w;
            int unsigned h;
            int unsigned k;
            int unsigned c;
            int unsigned r;
            bit          row_end;
            bit          img_end;
            bit          have_prev;
            out_item_t   px;
            out_item_t   prev;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            have_prev = 1'b0;
            for (k = 0; k < count; k++) begin
                c = col;
                r = row;
                row_end = (c + 1) >= w;
                img_end = row_end && ((r + 1) >= h);
                px.pixel        = palette[idx];
                px.column       = col;
                px.row          = row;
                px.last_of_run  = 1'b0;
                px.end_of_image = img_end;
                if (have_prev) queue_pixel(prev);
                prev      = px;
                have_prev = 1'b1;
                if (img_end) begin
                    // rest of the run falls off the end of the image
                    col = '0;
                    row = '0;
                    break;
                end
                if (row_end) begin
                    col = '0;
                    row = row + 12'd1;
                end else begin
                    col = col + 12'd1;
                end
            end
            if (have_prev) begin
                prev.last_of_run = 1'b1;
                queue_pixel(prev);
            end
        endfunction

        function void note_input(in_item_t it);
            int unsigned n;
            case (it.operation)
                OP_PALETTE: begin
                    palette[it.entry_index] = {it.red[7:3], it.green[7:2], it.blue[7:3]};
                end
                OP_RESTART: begin
                    armed     = 1'b0;
                    run_count = '0;
                    col       = '0;
                    row       = '0;
                end
                OP_DATA: begin
                    if (armed) begin
                        n         = run_count;
                        armed     = 1'b0;
                        run_count = '0;
                        paint_run(it.data_byte, n);
                    end else if (it.data_byte[7:6] == RUN_MARK) begin
                        armed     = 1'b1;
                        run_count = it.data_byte[5:0];
                    end else begin
                        paint_run(it.data_byte, 1);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (shown < 40) begin
                shown++;
                $display("mismatch: %s", msg);
            end
        endtask

        task check_pixel(out_item_t got);
            out_item_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel %h at (%0d,%0d) with nothing expected",
                                 got.pixel, got.column, got.row));
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.end_of_image) images_done++;
            if (got.pixel !== want.pixel)
                report($sformatf("colour at (%0d,%0d): %h, expected %h",
                                 want.column, want.row, got.pixel, want.pixel));
            if (got.column !== want.column)
                report($sformatf("column %0d, expected %0d", got.column, want.column));
            if (got.row !== want.row)
                report($sformatf("row %0d, expected %0d", got.row, want.row));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run at (%0d,%0d): %b, expected %b",
                                 want.column, want.row, got.last_of_run, want.last_of_run));
            if (got.end_of_image !== want.end_of_image)
                report($sformatf("end_of_image at (%0d,%0d): %b, expected %b",
                                 want.column, want.row, got.end_of_image, want.end_of_image));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pcx_rle_palette_decoder_core #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    pixel_scoreboard sb = new(MAX_DIM);

    // stimulus bookkeeping
    bit          loaded [PALETTE_ENTRIES];   // palette entries written so far
    bit          gen_armed       = 1'b0;     // marker sent, index byte still owed
    int unsigned snd_idle_pct    = 0;
    int unsigned rcv_idle_pct    = 0;
    int unsigned idle_mode       = 0;
    bit          long_hold_done  = 1'b0;
    int unsigned transfers_sent  = 0;
    int unsigned reg_writes      = 0;
    int unsigned cycle_count     = 0;

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still owed",
                     cycle_count, sb.pending());
            $display("pcx_rle_palette_decoder_core regression: fail");
            $finish;
        end
    end

    // monitor: values sampled at the edge are the ones before this edge's updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_pixel(m_item);
            if (s_valid && s_ready) sb.note_input(s_item);
        end
    end

    // receiver: random back-pressure, plus one long hold-off so the core backs up
    initial begin : rx_side
        int unsigned k;
        forever begin
            @(posedge aclk);
            if (idle_mode == 2 && !long_hold_done && sb.pending() > 0) begin
                m_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // drivers, all called at a rising edge
    // ------------------------------------------------------------------

    // offer one transfer, with random gaps ahead of it, and wait for acceptance
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.operation != OP_UNUSED) transfers_sent++;
    endtask

    task automatic load_entry(input logic [7:0] entry, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        in_item_t it;
        it.operation   = OP_PALETTE;
        it.data_byte   = 8'($urandom);
        it.entry_index = entry;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        loaded[entry]  = 1'b1;
        send_item(it);
    endtask

    task automatic ensure_entry(input logic [7:0] entry);
        if (!loaded[entry])
            load_entry(entry, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // data, restart or unused operation; unused fields carry noise
    task automatic send_op(input logic [1:0] op, input logic [7:0] value);
        in_item_t it;
        if (op == OP_DATA) begin
            // any byte that ends up as a palette index must point at a loaded entry
            if (gen_armed) begin
                ensure_entry(value);
                gen_armed = 1'b0;
            end else if (value[7:6] == RUN_MARK) begin
                gen_armed = 1'b1;
            end else begin
                ensure_entry(value);
            end
        end else if (op == OP_RESTART) begin
            gen_armed = 1'b0;
        end
        it.operation   = op;
        it.data_byte   = value;
        it.entry_index = 8'($urandom);
        it.red         = 8'($urandom);
        it.green       = 8'($urandom);
        it.blue        = 8'($urandom);
        send_item(it);
    endtask

    // both size registers back to back, valid held high across the pair
    task automatic set_dims(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(REG_IMAGE_WIDTH, w);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    // stop offering, let every owed pixel arrive, then give the core spare idle time
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one random stretch of stimulus, mostly well-formed runs and literals
    task automatic random_stretch(input int unsigned quota);
        int unsigned start;
        int unsigned kind;
        logic [5:0]  count;
        start = transfers_sent;
        while (transfers_sent - start < quota) begin
            kind = $urandom_range(99);
            if (kind < 38) begin
                // mostly short runs, now and then up to the full 63
                if ($urandom_range(3) == 0) count = 6'($urandom_range(63));
                else count = 6'($urandom_range(12));
                send_op(OP_DATA, {RUN_MARK, count});
                case ($urandom_range(19))
                    0: send_op(OP_UNUSED, 8'($urandom));
                    1: load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                    2: send_op(OP_RESTART, 8'($urandom));   // broken run
                    default: ;
                endcase
                send_op(OP_DATA, 8'($urandom));
            end else if (kind < 70) begin
                send_op(OP_DATA, 8'($urandom_range(191)));
            end else if (kind < 80) begin
                load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind < 86) begin
                send_op(OP_RESTART, 8'($urandom));
            end else if (kind < 92) begin
                send_op(OP_UNUSED, 8'($urandom));
            end else begin
                // stray marker, whatever comes next is taken as its index
                send_op(OP_DATA, {RUN_MARK, 6'($urandom)});
            end
        end
    endtask

    // image shapes per random stretch: tiny, single pixel, extremes, shrink below the
    // current position, out-of-range register values and the reset size
    int unsigned shape_w [SHAPES] = '{7, 1, 4096, 5, 0, 8191, 3, 640, 16};
    int unsigned shape_h [SHAPES] = '{4, 1, 1, 3, 6, 0, 8191, 480, 2};

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned s;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part on a 5 x 3 image so the end of image comes quickly
        snd_idle_pct = 6;
        rcv_idle_pct = 56;
        idle_mode    = 0;
        set_dims(13'd5, 13'd3);
        load_entry(8'h00, 8'h00, 8'h00, 8'h00);
        load_entry(8'hff, 8'hff, 8'hff, 8'hff);
        load_entry(8'hbf, 8'hff, 8'h00, 8'hff);
        load_entry(8'h40, 8'h07, 8'h03, 8'h07);   // low bits only, truncates to black
        send_op(OP_UNUSED, 8'($urandom));          // ignored entirely
        send_op(OP_DATA, 8'h00);                   // literal, lowest index
        send_op(OP_DATA, 8'hbf);                   // literal, highest non-marker byte
        send_op(OP_DATA, 8'hc0);                   // zero-length run
        send_op(OP_DATA, 8'hff);
        send_op(OP_DATA, 8'hc1);                   // run of one
        send_op(OP_DATA, 8'h40);
        send_op(OP_DATA, 8'hff);                   // run of 63, wraps rows and hits image end
        send_op(OP_DATA, 8'hff);
        send_op(OP_DATA, 8'h00);                   // back at the origin
        send_op(OP_DATA, 8'hc5);                   // restart cancels the armed run
        send_op(OP_RESTART, 8'($urandom));
        send_op(OP_DATA, 8'hbf);
        send_op(OP_DATA, 8'hc3);                   // palette write while armed keeps the run
        load_entry(8'h40, 8'h80, 8'hfc, 8'h08);
        send_op(OP_DATA, 8'h40);
        send_op(OP_DATA, 8'hc2);                   // unused operation while armed
        send_op(OP_UNUSED, 8'($urandom));
        send_op(OP_DATA, 8'h00);
        send_op(OP_RESTART, 8'($urandom));
        settle();

        // random part: three idling regimes, three image shapes in each
        for (s = 0; s < SHAPES; s++) begin
            idle_mode = s / 3;
            case (idle_mode)
                0: begin snd_idle_pct = 6;  rcv_idle_pct = 56; end
                1: begin snd_idle_pct = 56; rcv_idle_pct = 6;  end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            set_dims(13'(shape_w[s]), 13'(shape_h[s]));
            random_stretch(ITEMS_PER_SHAPE);
            settle();
        end

        $display("covered %0d input transfers and %0d register writes over %0d image shapes",
                 transfers_sent, reg_writes, SHAPES + 1);
        $display("checked %0d pixels, %0d complete images, %0d mismatches",
                 sb.pixels_checked, sb.images_done, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("pcx_rle_palette_decoder_core regression: pass");
        end else begin
            $display("pcx_rle_palette_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
